@@ design/pal_pkg.sv @@
// Package for positional_array_list: list sizes, field widths, operation
// and status codes, sequencer states and the store request struct.
// No dependencies.
package pal_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  localparam int KIND_W   = 2;
  localparam int POS_W    = 9;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // Wide enough to compare a position against length + 1 without wrap.
  localparam int CMP_W    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_INS_PUT,
    S_DEL_GOT,
    S_SHIFT_DN,
    S_RD_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ design/pal_store.sv @@
// Element store: CAPACITY x 32-bit memory, one write port and one read
// port with registered read data. Depends on pal_pkg.
module pal_store (
  input  logic                          clk,
  input  pal_pkg::mem_req_t             req,
  output logic [pal_pkg::VAL_W-1:0]     rdata
);
  import pal_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ design/pal_ctrl.sv @@
// Sequencer for positional_array_list: range checks, entry moves through
// the store one per cycle, length tracking and the output register.
// Depends on pal_pkg; drives pal_store through a mem_req_t.
module pal_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pal_pkg::KIND_W-1:0]     kind,
  input  logic [pal_pkg::POS_W-1:0]      position,
  input  logic [pal_pkg::VAL_W-1:0]      value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pal_pkg::STATUS_W-1:0]   status,
  output logic [pal_pkg::VAL_W-1:0]      element,
  output logic [pal_pkg::COUNT_W-1:0]    count,
  output pal_pkg::mem_req_t              mreq,
  input  logic [pal_pkg::VAL_W-1:0]      rdata
);
  import pal_pkg::*;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  pos_idx, pos_idx_next;
  logic [VAL_W-1:0]   val, val_next;
  logic [ADDR_W-1:0]  wr, wr_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [VAL_W-1:0]   got, got_next;
  status_t            stat, stat_next;
  logic               out_valid_next;
  logic [STATUS_W-1:0] status_next;
  logic [VAL_W-1:0]   element_next;
  logic [COUNT_W-1:0] count_next;

  logic [CMP_W-1:0]   pos_ext, len_ext;
  logic               pos_bad_ins, pos_bad_acc;

  assign in_stall    = (state != S_IDLE);
  assign pos_ext     = CMP_W'(position);
  assign len_ext     = CMP_W'(len);
  assign pos_bad_ins = (position == '0) || (pos_ext > len_ext + CMP_W'(1));
  assign pos_bad_acc = (position == '0) || (pos_ext > len_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos_idx <= pos_idx_next;
    val     <= val_next;
    wr      <= wr_next;
    got     <= got_next;
    stat    <= stat_next;
    status  <= status_next;
    element <= element_next;
    count   <= count_next;
  end

  always_comb begin
    state_next     = state;
    pos_idx_next   = pos_idx;
    val_next       = val;
    wr_next        = wr;
    len_next       = len;
    got_next       = got;
    stat_next      = stat;
    status_next    = status;
    element_next   = element;
    count_next     = count;
    out_valid_next = out_valid && out_stall;
    mreq           = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          pos_idx_next = ADDR_W'(position - POS_W'(1));
          val_next     = value;
          got_next     = '0;
          stat_next    = STATUS_OK;
          state_next   = S_FINISH;
          case (kind)
            KIND_INSERT: begin
              if (pos_bad_ins) begin
                stat_next = STATUS_RANGE;
              end else if (len == LEN_W'(CAPACITY)) begin
                stat_next = STATUS_FULL;
              end else if (pos_ext == len_ext + CMP_W'(1)) begin
                // append: nothing to move
                mreq.we    = 1'b1;
                mreq.waddr = ADDR_W'(len);
                mreq.wdata = value;
                len_next   = len + LEN_W'(1);
              end else begin
                mreq.raddr = ADDR_W'(len - LEN_W'(1));
                wr_next    = ADDR_W'(len);
                state_next = S_SHIFT_UP;
              end
            end
            KIND_DELETE: begin
              if (pos_bad_acc) begin
                stat_next = STATUS_RANGE;
              end else begin
                mreq.raddr = ADDR_W'(position - POS_W'(1));
                state_next = S_DEL_GOT;
              end
            end
            KIND_READ: begin
              if (pos_bad_acc) begin
                stat_next = STATUS_RANGE;
              end else begin
                mreq.raddr = ADDR_W'(position - POS_W'(1));
                state_next = S_RD_WAIT;
              end
            end
            default: begin
              stat_next = STATUS_RANGE;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        // rdata holds entry wr-1
        mreq.we    = 1'b1;
        mreq.waddr = wr;
        mreq.wdata = rdata;
        if (wr == pos_idx + ADDR_W'(1)) begin
          state_next = S_INS_PUT;
        end else begin
          mreq.raddr = wr - ADDR_W'(2);
          wr_next    = wr - ADDR_W'(1);
        end
      end
      S_INS_PUT: begin
        mreq.we    = 1'b1;
        mreq.waddr = pos_idx;
        mreq.wdata = val;
        len_next   = len + LEN_W'(1);
        state_next = S_FINISH;
      end
      S_DEL_GOT: begin
        got_next = rdata;
        if (LEN_W'(pos_idx) + LEN_W'(1) == len) begin
          len_next   = len - LEN_W'(1);
          state_next = S_FINISH;
        end else begin
          mreq.raddr = pos_idx + ADDR_W'(1);
          wr_next    = pos_idx;
          state_next = S_SHIFT_DN;
        end
      end
      S_SHIFT_DN: begin
        // rdata holds entry wr+1
        mreq.we    = 1'b1;
        mreq.waddr = wr;
        mreq.wdata = rdata;
        if (LEN_W'(wr) + LEN_W'(2) == len) begin
          len_next   = len - LEN_W'(1);
          state_next = S_FINISH;
        end else begin
          mreq.raddr = wr + ADDR_W'(2);
          wr_next    = wr + ADDR_W'(1);
        end
      end
      S_RD_WAIT: begin
        got_next   = rdata;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          status_next    = stat;
          element_next   = got;
          count_next     = COUNT_W'(len);
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/positional_array_list.sv @@
// Top level of positional_array_list: bounded list with insert, delete and
// read by 1-based position. Instantiates pal_ctrl and pal_store (pal_pkg).
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------
//   input   | in_valid  | in_stall  | kind, position, value
//   output  | out_valid | out_stall | status, element, count
//
// One transaction at a time. An insert at position p shifts the entries from p
// onward up by one, and a delete shifts those after p down by one, moving one
// entry per cycle through the single store port pair.
// Reset (rst, synchronous) empties the list; stored entries are not cleared.
// A finished result waits in the output register while the next transaction
// is taken; the sequencer holds only if that register is still stalled.
module positional_array_list (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pal_pkg::KIND_W-1:0]     kind,
  input  logic [pal_pkg::POS_W-1:0]      position,
  input  logic [pal_pkg::VAL_W-1:0]      value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pal_pkg::STATUS_W-1:0]   status,
  output logic [pal_pkg::VAL_W-1:0]      element,
  output logic [pal_pkg::COUNT_W-1:0]    count
);
  import pal_pkg::*;

  mem_req_t         mreq;
  logic [VAL_W-1:0] rdata;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .element   (element),
    .count     (count),
    .mreq      (mreq),
    .rdata     (rdata)
  );

  pal_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

endmodule

@@ verif/positional_array_list_test.sv @@
// Self-checking testbench for positional_array_list: directed table, then random
// fill/drain traffic with handshake gaps and backpressure, checked against a
// local list predictor. Depends on pal_pkg and the positional_array_list RTL.
module positional_array_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int RANDOM_OPS = 830;
  localparam int HOLD_START = 200;
  localparam int HOLD_CYCLES = 400;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    status_t status;
    logic [VAL_W-1:0] element;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    bit typed;
    list_result_t res;
  } op_row_t;

  // typed rows carry a hand-written result; the rest go through the predictor
  localparam op_row_t DIRECTED_OPS [0:23] = '{
    '{KIND_READ, 9'd1, 32'h0000_0000, 1'b1, '{STATUS_RANGE, 32'd0, 9'd0}},
    '{KIND_DELETE, 9'd0, 32'h0000_0000, 1'b1, '{STATUS_RANGE, 32'd0, 9'd0}},
    '{KIND_INSERT, 9'd2, 32'h1234_5678, 1'b1, '{STATUS_RANGE, 32'd0, 9'd0}},
    '{KIND_INSERT, 9'd0, 32'h1234_5678, 1'b1, '{STATUS_RANGE, 32'd0, 9'd0}},
    '{KIND_UNUSED, 9'd1, 32'hFFFF_FFFF, 1'b1, '{STATUS_RANGE, 32'd0, 9'd0}},
    '{KIND_INSERT, 9'd1, 32'h7FFF_FFFF, 1'b1, '{STATUS_OK, 32'd0, 9'd1}},
    '{KIND_INSERT, 9'd1, 32'h8000_0000, 1'b1, '{STATUS_OK, 32'd0, 9'd2}},
    '{KIND_INSERT, 9'd3, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 32'd0, 9'd3}},
    '{KIND_INSERT, 9'd2, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'd0, 9'd0}},
    '{KIND_INSERT, 9'd6, 32'h0000_0001, 1'b1, '{STATUS_RANGE, 32'd0, 9'd4}},
    '{KIND_INSERT, 9'd511, 32'hFFFF_FFFF, 1'b1, '{STATUS_RANGE, 32'd0, 9'd4}},
    '{KIND_READ, 9'd1, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'd0, 9'd0}},
    '{KIND_READ, 9'd4, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'd0, 9'd0}},
    '{KIND_READ, 9'd5, 32'h0000_0000, 1'b1, '{STATUS_RANGE, 32'd0, 9'd4}},
    '{KIND_READ, 9'd0, 32'h0000_0000, 1'b1, '{STATUS_RANGE, 32'd0, 9'd4}},
    '{KIND_DELETE, 9'd5, 32'h0000_0000, 1'b1, '{STATUS_RANGE, 32'd0, 9'd4}},
    '{KIND_DELETE, 9'd511, 32'hFFFF_FFFF, 1'b1, '{STATUS_RANGE, 32'd0, 9'd4}},
    '{KIND_DELETE, 9'd2, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'd0, 9'd0}},
    '{KIND_DELETE, 9'd3, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'd0, 9'd0}},
    '{KIND_DELETE, 9'd1, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'd0, 9'd0}},
    '{KIND_INSERT, 9'd2, 32'h5A5A_A5A5, 1'b0, '{STATUS_OK, 32'd0, 9'd0}},
    '{KIND_READ, 9'd2, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'd0, 9'd0}},
    '{KIND_UNUSED, 9'd511, 32'h0000_0000, 1'b1, '{STATUS_RANGE, 32'd0, 9'd2}},
    '{KIND_READ, 9'd256, 32'h0000_0000, 1'b1, '{STATUS_RANGE, 32'd0, 9'd2}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [POS_W-1:0] position = '0;
  logic [VAL_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0] element;
  logic [COUNT_W-1:0] count;

  // predictor state
  logic [VAL_W-1:0] shadow_entries [CAPACITY];
  int shadow_len = 0;
  int peak_len = 0;

  list_result_t pending_results [$];
  list_result_t head_result;
  int accepted_ops = 0;
  int checked_results = 0;
  int status_seen [3] = '{0, 0, 0};
  int errors = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  positional_array_list i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .element(element),
    .count(count)
  );

  always #CLK_HALF clk = ~clk;

  function automatic list_result_t list_apply(logic [KIND_W-1:0] op, logic [POS_W-1:0] pos,
                                              logic [VAL_W-1:0] val);
    list_result_t r;
    int p;
    int j;
    p = pos;
    r.status = STATUS_OK;
    r.element = '0;
    case (op)
      KIND_INSERT: begin
        if (p < 1 || p > shadow_len + 1) begin
          r.status = STATUS_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          for (j = shadow_len; j >= p; j--) shadow_entries[j] = shadow_entries[j-1];
          shadow_entries[p-1] = val;
          shadow_len++;
        end
      end
      KIND_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          r.status = STATUS_RANGE;
        end else begin
          r.element = shadow_entries[p-1];
          for (j = p; j < shadow_len; j++) shadow_entries[j-1] = shadow_entries[j];
          shadow_len--;
        end
      end
      KIND_READ: begin
        if (p < 1 || p > shadow_len) r.status = STATUS_RANGE;
        else r.element = shadow_entries[p-1];
      end
      default: r.status = STATUS_RANGE;
    endcase
    if (shadow_len > peak_len) peak_len = shadow_len;
    r.count = COUNT_W'(shadow_len);
    return r;
  endfunction

  // no gaps and no backpressure in this window
  function automatic bit steady_window();
    return accepted_ops >= 450 && accepted_ops < 560;
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("%0t ERROR %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  // Offer one transaction from the falling edge, with random gaps ahead of it;
  // the expectation is recorded when the transaction is accepted.
  task automatic send_op(logic [KIND_W-1:0] op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                         bit typed, list_result_t typed_res);
    list_result_t predicted;
    @(negedge clk);
    if (!steady_window()) begin
      while ($urandom_range(99) < 23) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    kind <= op;
    position <= pos;
    value <= val;
    do @(posedge clk); while (in_stall);
    predicted = list_apply(op, pos, val);
    pending_results.push_back(typed ? typed_res : predicted);
    accepted_ops++;
  endtask

  // receiver: random stalls, one long hold-off, one quiet stretch
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && accepted_ops >= HOLD_START) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (steady_window()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 23);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending", element, '0);
      end else begin
        head_result = pending_results.pop_front();
        if (status !== head_result.status)
          report_mismatch("status", VAL_W'(status), VAL_W'(head_result.status));
        if (element !== head_result.element)
          report_mismatch("element", element, head_result.element);
        if (count !== head_result.count)
          report_mismatch("count", VAL_W'(count), VAL_W'(head_result.count));
        status_seen[head_result.status]++;
        checked_results++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("positional_array_list: mismatch");
    $finish;
  end

  initial begin
    logic [KIND_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int roll;
    int n;
    int full_tries;
    bit filling;
    full_tries = 0;
    filling = 1'b1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_OPS[i])
      send_op(DIRECTED_OPS[i].op, DIRECTED_OPS[i].pos, DIRECTED_OPS[i].val,
              DIRECTED_OPS[i].typed, DIRECTED_OPS[i].res);

    // Grow the list to capacity, sit at full for a few tries, then drain it.
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (filling && shadow_len == CAPACITY) begin
        full_tries++;
        if (full_tries > 10) filling = 1'b0;
      end else if (!filling && shadow_len == 0) begin
        filling = 1'b1;
        full_tries = 0;
      end

      roll = $urandom_range(99);
      if (roll < 2) op = KIND_UNUSED;
      else if (roll < (filling ? 80 : 10)) op = KIND_INSERT;
      else if (roll < 88) op = filling ? KIND_DELETE : KIND_READ;
      else op = filling ? KIND_READ : KIND_DELETE;
      // draining: delete takes the large share
      if (!filling && roll >= 10 && roll < 76) op = KIND_DELETE;

      if (op == KIND_UNUSED || $urandom_range(99) < 7) begin
        case ($urandom_range(3))
          0: pos = '0;
          1: pos = POS_W'(op == KIND_INSERT ? shadow_len + 2 : shadow_len + 1);
          2: pos = '1;
          default: pos = POS_W'($urandom);
        endcase
      end else if (op == KIND_INSERT) begin
        pos = POS_W'($urandom_range(shadow_len + 1, 1));
      end else if (shadow_len == 0) begin
        pos = POS_W'($urandom_range(3));
      end else begin
        pos = POS_W'($urandom_range(shadow_len, 1));
      end

      case ($urandom_range(11))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = '1;
        3: val = '0;
        default: val = $urandom;
      endcase

      send_op(op, pos, val, 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    $display("%0d transactions checked: %0d ok, %0d out of range, %0d full",
             checked_results, status_seen[STATUS_OK], status_seen[STATUS_RANGE],
             status_seen[STATUS_FULL]);
    $display("list peaked at %0d of %0d entries, output held off %0d cycles once",
             peak_len, CAPACITY, HOLD_CYCLES);
    if (errors == 0) begin
      $display("positional_array_list: match");
    end else begin
      $display("positional_array_list: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/pal_pkg.sv
design/pal_store.sv
design/pal_ctrl.sv
design/positional_array_list.sv
verif/positional_array_list_test.sv
